### src/ufr_pkg.sv
// ----------------------------------------------------------------------------
// ufr_pkg: shared definitions for the framed UART receiver
// Frame constants, controller-to-datapath command and status structs, CRC step.
// ----------------------------------------------------------------------------
package ufr_pkg;

	localparam int BUFFER_BYTES = 128;
	localparam int MAX_RESULTS  = 30;
	localparam int MIN_FRAME    = 10;

	localparam logic [7:0]  SYNC0      = 8'h55;
	localparam logic [7:0]  SYNC1      = 8'hAA;
	localparam logic [15:0] CRC_INIT   = 16'hFFFF;
	localparam logic [15:0] CRC_POLY   = 16'hA001;
	localparam logic [7:0]  RESP_RESET = 8'd1;
	localparam logic [7:0]  EVT_RESET  = 8'd2;

	// byte positions inside an aligned frame
	localparam int POS_CRC_START = 2;
	localparam int POS_TYPE      = 3;
	localparam int POS_CMD       = 4;
	localparam int POS_SEQ       = 5;
	localparam int POS_LEN_LO    = 6;
	localparam int POS_LEN_HI    = 7;
	localparam int POS_PAYLOAD   = 8;

	typedef enum logic [2:0] {
		IDX_HOLD,
		IDX_ZERO,
		IDX_CRC,
		IDX_HDR,
		IDX_PAY,
		IDX_INC
	} idx_op_t;

	typedef struct packed {
		logic    append;
		logic    clear;
		logic    rd;
		idx_op_t idx_op;
		logic    hunt_cap;
		logic    drop;
		logic    hdr_cap;
		logic    crc_init;
		logic    crc_cap;
		logic    rxlo_cap;
		logic    word_cap;
		logic    emit_add;
		logic    out_load;
		logic    consume;
		logic    emit_clr;
	} ufr_cmd_t;

	typedef struct packed {
		logic full;
		logic lt_min;
		logic hunt_hit;
		logic hunt_end;
		logic hdr_last;
		logic len_bad;
		logic len_short;
		logic at_last;
		logic pay_done;
		logic frame_ok;
		logic word_full;
		logic out_busy;
	} ufr_sts_t;

	function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in, input logic [7:0] data);
		logic [15:0] c;
		c = crc_in ^ {8'h00, data};
		for (int b = 0; b < 8; b++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

### src/ufr_ram.sv
// ----------------------------------------------------------------------------
// ufr_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ufr_ram #(
	parameter int Width = 8,
	parameter int Depth = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### src/ufr_datapath.sv
// ----------------------------------------------------------------------------
// ufr_datapath: receive buffer, pointers, CRC and output word register
// Circular byte buffer with head pointer and fill count; acts on controller commands.
// ----------------------------------------------------------------------------
module ufr_datapath #(
	parameter int BufferBytes = ufr_pkg::BUFFER_BYTES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ufr_pkg::ufr_cmd_t cmd,
	output ufr_pkg::ufr_sts_t sts,
	input  logic [7:0]        rx_byte,
	input  logic [7:0]        response_type_code,
	input  logic [7:0]        event_type_code,
	input  logic              out_ready,
	output logic              out_valid,
	output logic              frame_kind,
	output logic [7:0]        command_id,
	output logic [7:0]        sequence_number,
	output logic [6:0]        payload_length,
	output logic [31:0]       payload_word,
	output logic [2:0]        word_byte_count,
	output logic              last_word
);

	localparam int AW = $clog2(BufferBytes);
	localparam int CW = $clog2(BufferBytes + 1);

	logic [AW-1:0] head_q;
	logic [CW-1:0] fill_q;
	logic [CW-1:0] idx_q;
	logic [7:0]    prev_q;
	logic [7:0]    typ_q;
	logic [7:0]    cmd_q;
	logic [7:0]    seq_q;
	logic [15:0]   plen_q;
	logic [15:0]   crc_q;
	logic [7:0]    rxlo_q;
	logic [31:0]   word_q;
	logic [2:0]    cnt_q;
	logic [4:0]    emit_cnt_q;
	logic          out_valid_q;
	logic          kind_q;
	logic [7:0]    ocmd_q;
	logic [7:0]    oseq_q;
	logic [6:0]    olen_q;
	logic [31:0]   oword_q;
	logic [2:0]    ocnt_q;
	logic          olast_q;

	logic [7:0]    rdata;
	logic [AW-1:0] waddr;
	logic [AW-1:0] raddr;
	logic [CW-1:0] plen_n;
	logic [CW-1:0] flen_n;
	logic [CW-1:0] skip_n;
	logic [CW:0]   words_n;
	logic [CW+1:0] emit_sum;
	logic          type_ok;

	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base, input logic [CW-1:0] off);
		logic [CW:0] sum;
		sum = {{(CW+1-AW){1'b0}}, base} + {1'b0, off};
		if (sum >= (CW+1)'(BufferBytes)) begin
			sum = sum - (CW+1)'(BufferBytes);
		end
		return sum[AW-1:0];
	endfunction

	assign waddr  = wrap_add(head_q, fill_q);
	assign raddr  = wrap_add(head_q, idx_q);
	assign plen_n = plen_q[CW-1:0];
	assign flen_n = plen_n + CW'(ufr_pkg::MIN_FRAME);
	assign skip_n = idx_q - CW'(1);

	assign words_n  = (plen_n == '0) ? (CW+1)'(1) : (({1'b0, plen_n} + (CW+1)'(3)) >> 2);
	assign emit_sum = {{(CW-3){1'b0}}, emit_cnt_q} + {1'b0, words_n};
	assign type_ok  = (typ_q == response_type_code) || (typ_q == event_type_code);

	ufr_ram #(
		.Width(8),
		.Depth(BufferBytes)
	) u_buf (
		.clk  (clk),
		.we   (cmd.append),
		.waddr(waddr),
		.wdata(rx_byte),
		.re   (cmd.rd),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_comb begin
		sts.full      = fill_q == CW'(BufferBytes);
		sts.lt_min    = fill_q < CW'(ufr_pkg::MIN_FRAME);
		sts.hunt_hit  = (idx_q != '0) && (prev_q == ufr_pkg::SYNC0) && (rdata == ufr_pkg::SYNC1);
		sts.hunt_end  = idx_q == (fill_q - CW'(1));
		sts.hdr_last  = idx_q == CW'(ufr_pkg::POS_LEN_HI);
		sts.len_bad   = ({1'b0, plen_q} + 17'(ufr_pkg::MIN_FRAME)) > 17'(BufferBytes);
		sts.len_short = fill_q < flen_n;
		sts.at_last   = idx_q == (plen_n + CW'(ufr_pkg::POS_LEN_HI));
		sts.pay_done  = idx_q == (plen_n + CW'(ufr_pkg::POS_PAYLOAD));
		sts.frame_ok  = ({rdata, rxlo_q} == crc_q) && type_ok
			&& (emit_sum <= (CW+2)'(ufr_pkg::MAX_RESULTS));
		sts.word_full = cnt_q == 3'd3;
		sts.out_busy  = out_valid_q && !out_ready;
	end

	// pointers and handshake state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			fill_q      <= '0;
			emit_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.append) begin
				fill_q <= fill_q + CW'(1);
			end else if (cmd.clear) begin
				fill_q <= '0;
			end else if (cmd.drop) begin
				head_q <= wrap_add(head_q, skip_n);
				fill_q <= fill_q - skip_n;
			end else if (cmd.consume) begin
				head_q <= wrap_add(head_q, flen_n);
				fill_q <= fill_q - flen_n;
			end
			if (cmd.emit_clr) begin
				emit_cnt_q <= '0;
			end else if (cmd.emit_add) begin
				emit_cnt_q <= emit_sum[4:0];
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (cmd.idx_op)
			ufr_pkg::IDX_ZERO: idx_q <= '0;
			ufr_pkg::IDX_CRC:  idx_q <= CW'(ufr_pkg::POS_CRC_START);
			ufr_pkg::IDX_HDR:  idx_q <= CW'(ufr_pkg::POS_TYPE);
			ufr_pkg::IDX_PAY:  idx_q <= CW'(ufr_pkg::POS_PAYLOAD);
			ufr_pkg::IDX_INC:  idx_q <= idx_q + CW'(1);
			default:           idx_q <= idx_q;
		endcase
		if (cmd.hunt_cap) begin
			prev_q <= rdata;
		end
		if (cmd.hdr_cap) begin
			case (idx_q)
				CW'(ufr_pkg::POS_TYPE):   typ_q <= rdata;
				CW'(ufr_pkg::POS_CMD):    cmd_q <= rdata;
				CW'(ufr_pkg::POS_SEQ):    seq_q <= rdata;
				CW'(ufr_pkg::POS_LEN_LO): plen_q[7:0] <= rdata;
				default:                  plen_q[15:8] <= rdata;
			endcase
		end
		if (cmd.crc_init) begin
			crc_q <= ufr_pkg::CRC_INIT;
		end else if (cmd.crc_cap) begin
			crc_q <= ufr_pkg::crc16_byte(crc_q, rdata);
		end
		if (cmd.rxlo_cap) begin
			rxlo_q <= rdata;
		end
		if (cmd.emit_add || cmd.out_load) begin
			word_q <= '0;
			cnt_q  <= '0;
		end else if (cmd.word_cap) begin
			word_q[8*cnt_q[1:0] +: 8] <= rdata;
			cnt_q <= cnt_q + 3'd1;
		end
		if (cmd.out_load) begin
			kind_q  <= typ_q != response_type_code;
			ocmd_q  <= cmd_q;
			oseq_q  <= seq_q;
			olen_q  <= plen_q[6:0];
			oword_q <= word_q;
			ocnt_q  <= cnt_q;
			olast_q <= sts.pay_done;
		end
	end

	assign out_valid       = out_valid_q;
	assign frame_kind      = kind_q;
	assign command_id      = ocmd_q;
	assign sequence_number = oseq_q;
	assign payload_length  = olen_q;
	assign payload_word    = oword_q;
	assign word_byte_count = ocnt_q;
	assign last_word       = olast_q;

endmodule

### src/ufr_ctrl.sv
// ----------------------------------------------------------------------------
// ufr_ctrl: parse sequencer
// Steps hunt, header read, length check, CRC pass, word emission and consume per byte.
// ----------------------------------------------------------------------------
module ufr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  ufr_pkg::ufr_sts_t sts,
	output ufr_pkg::ufr_cmd_t cmd
);

	typedef enum logic [4:0] {
		S_IDLE, S_CHK, S_HUNT_RD, S_HUNT_DAT, S_HDR_CHK, S_HDR_RD, S_HDR_DAT,
		S_LEN_CHK, S_CRC_RD, S_CRC_DAT, S_RXL_RD, S_RXL_DAT, S_RXH_RD, S_RXH_DAT,
		S_EM_START, S_EM_NEXT, S_EM_RD, S_EM_DAT, S_EM_OUT, S_CONSUME
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.append   = !sts.full;
					cmd.clear    = sts.full;
					cmd.emit_clr = 1'b1;
					state_d      = S_CHK;
				end
			end
			S_CHK: begin
				if (sts.lt_min) begin
					state_d = S_IDLE;
				end else begin
					cmd.idx_op = ufr_pkg::IDX_ZERO;
					state_d    = S_HUNT_RD;
				end
			end
			S_HUNT_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_HUNT_DAT;
			end
			S_HUNT_DAT: begin
				cmd.hunt_cap = 1'b1;
				if (sts.hunt_hit) begin
					cmd.drop = 1'b1;
					state_d  = S_HDR_CHK;
				end else if (sts.hunt_end) begin
					cmd.clear = 1'b1;
					state_d   = S_CHK;
				end else begin
					cmd.idx_op = ufr_pkg::IDX_INC;
					state_d    = S_HUNT_RD;
				end
			end
			S_HDR_CHK: begin
				if (sts.lt_min) begin
					state_d = S_IDLE;
				end else begin
					cmd.idx_op = ufr_pkg::IDX_HDR;
					state_d    = S_HDR_RD;
				end
			end
			S_HDR_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_HDR_DAT;
			end
			S_HDR_DAT: begin
				cmd.hdr_cap = 1'b1;
				cmd.idx_op  = ufr_pkg::IDX_INC;
				state_d     = sts.hdr_last ? S_LEN_CHK : S_HDR_RD;
			end
			S_LEN_CHK: begin
				if (sts.len_bad) begin
					cmd.clear = 1'b1;
					state_d   = S_CHK;
				end else if (sts.len_short) begin
					state_d = S_IDLE;
				end else begin
					cmd.idx_op   = ufr_pkg::IDX_CRC;
					cmd.crc_init = 1'b1;
					state_d      = S_CRC_RD;
				end
			end
			S_CRC_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_CRC_DAT;
			end
			S_CRC_DAT: begin
				cmd.crc_cap = 1'b1;
				cmd.idx_op  = ufr_pkg::IDX_INC;
				state_d     = sts.at_last ? S_RXL_RD : S_CRC_RD;
			end
			S_RXL_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_RXL_DAT;
			end
			S_RXL_DAT: begin
				cmd.rxlo_cap = 1'b1;
				cmd.idx_op   = ufr_pkg::IDX_INC;
				state_d      = S_RXH_RD;
			end
			S_RXH_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_RXH_DAT;
			end
			S_RXH_DAT: begin
				state_d = sts.frame_ok ? S_EM_START : S_CONSUME;
			end
			S_EM_START: begin
				cmd.emit_add = 1'b1;
				cmd.idx_op   = ufr_pkg::IDX_PAY;
				state_d      = S_EM_NEXT;
			end
			S_EM_NEXT: begin
				state_d = sts.pay_done ? S_EM_OUT : S_EM_RD;
			end
			S_EM_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_EM_DAT;
			end
			S_EM_DAT: begin
				cmd.word_cap = 1'b1;
				cmd.idx_op   = ufr_pkg::IDX_INC;
				state_d      = (sts.at_last || sts.word_full) ? S_EM_OUT : S_EM_RD;
			end
			S_EM_OUT: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = sts.pay_done ? S_CONSUME : S_EM_RD;
				end
			end
			S_CONSUME: begin
				cmd.consume = 1'b1;
				state_d     = S_CHK;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### src/uart_frame_receiver_crc16.sv
// ----------------------------------------------------------------------------
// uart_frame_receiver_crc16: sync-word framed receiver with CRC-16 check
// Buffers serial bytes, aligns on 55 AA, checks CRC-16 and emits frame words.
// ----------------------------------------------------------------------------
// Each buffer read is a read state then a data state (one RAM read port).
// Busy after a taken byte: below 10 bytes, only the fill check; with no sync word,
// hunt and clear; then header read and, for a complete frame, CRC pass and consume;
// a good one adds word emission and any out_ready stall per word. Consume reparses.
// Throughput: one byte at a time; in_ready is high only while the sequencer idles.
// Reset: buffer emptied, type codes back to 1 and 2; buffer RAM is not cleared.
module uart_frame_receiver_crc16 #(
	parameter int BufferBytes = ufr_pkg::BUFFER_BYTES
) (
	input  logic        clk,
	input  logic        arst_n,
	// byte input
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	// result words
	output logic        out_valid,
	input  logic        out_ready,
	output logic        frame_kind,
	output logic [7:0]  command_id,
	output logic [7:0]  sequence_number,
	output logic [6:0]  payload_length,
	output logic [31:0] payload_word,
	output logic [2:0]  word_byte_count,
	output logic        last_word,
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// register index sits at address bit 2
	localparam logic REG_RESP = 1'b0;
	localparam logic REG_EVT  = 1'b1;

	logic [7:0]        resp_code_q;
	logic [7:0]        evt_code_q;
	logic              reg_wr;
	ufr_pkg::ufr_cmd_t cmd;
	ufr_pkg::ufr_sts_t sts;

	// Register port: pready tied high, write on the access phase.
	assign pready = 1'b1;
	assign reg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resp_code_q <= ufr_pkg::RESP_RESET;
			evt_code_q  <= ufr_pkg::EVT_RESET;
		end else if (reg_wr) begin
			if (paddr[2] == REG_RESP) begin
				resp_code_q <= pwdata[7:0];
			end
			if (paddr[2] == REG_EVT) begin
				evt_code_q <= pwdata[7:0];
			end
		end
	end

	assign prdata = {24'h000000, (paddr[2] == REG_EVT) ? evt_code_q : resp_code_q};

	// Sequencer: hunts the sync word, reads header, runs the CRC pass and
	// walks the payload four bytes per word.
	ufr_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	// Datapath: circular buffer (head pointer plus fill count, so dropping
	// leading bytes or a consumed frame is a pointer advance), CRC register
	// and the output word register.
	ufr_datapath #(
		.BufferBytes(BufferBytes)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.rx_byte           (rx_byte),
		.response_type_code(resp_code_q),
		.event_type_code   (evt_code_q),
		.out_ready         (out_ready),
		.out_valid         (out_valid),
		.frame_kind        (frame_kind),
		.command_id        (command_id),
		.sequence_number   (sequence_number),
		.payload_length    (payload_length),
		.payload_word      (payload_word),
		.word_byte_count   (word_byte_count),
		.last_word         (last_word)
	);

	// A taken byte always makes in_ready drop.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready right after accepting a word");

	// Only the final word of a frame may be partly filled.
	a_partial_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_word |-> word_byte_count == 3'd4)
		else $error("partial payload word not marked last");

	// An empty word only comes from an empty payload.
	a_empty_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && word_byte_count == 3'd0 |-> last_word && payload_length == 7'd0
			&& payload_word == 32'd0)
		else $error("empty word outside an empty frame");

	// A result does not appear while the receiver idles without input.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready && !out_valid |=> !(out_valid && !$past(in_valid)) || !in_ready)
		else $error("result produced while idle without input");

endmodule
